// ===== rtl/core/tcw_pkg.sv =====
// ----------------------------------------------------------------------------
// tcw_pkg
// Shared types and constants of the text console writer: transaction
// payloads, controller/datapath command and status groups, character codes.
// ----------------------------------------------------------------------------
package tcw_pkg;

  // Default screen geometry
  localparam int COLUMNS_DEFAULT = 80;
  localparam int ROWS_DEFAULT    = 25;

  // Character and attribute codes
  localparam logic [7:0]  NEWLINE_CODE     = 8'h0A;
  localparam logic [7:0]  BLANK_CODE       = 8'h20;
  localparam logic [7:0]  TEXT_COLOR_RESET = 8'h07;
  localparam logic [15:0] RESET_CELL       = 16'h0720;

  // Item operation codes
  localparam logic MODE_PUT  = 1'b0;
  localparam logic MODE_READ = 1'b1;

  // Input transaction
  typedef struct packed {
    logic        mode;
    logic [7:0]  char_code;
    logic [10:0] cell_index;
  } item_t;

  // Result transaction
  typedef struct packed {
    logic [10:0] cursor_offset;
    logic [15:0] cell_data;
    logic        scrolled;
  } result_t;

  // Controller to datapath commands
  typedef struct packed {
    logic accept;    // latch item, do put write or read, move cursor
    logic clear_wr;  // post-reset clearing pass, one cell
    logic copy_rd;   // scroll: read source cell one row down
    logic copy_wr;   // scroll: write read cell one row up
    logic blank_wr;  // scroll: blank one cell of the bottom row
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic will_scroll;  // item at the input scrolls the screen
    logic copy_last;    // counter at last cell of the copy
    logic fill_last;    // counter at last cell of the store
  } sts_t;

endpackage

// ===== rtl/core/tcw_ctrl.sv =====
// ----------------------------------------------------------------------------
// tcw_ctrl
// Controller state machine: clearing pass, item accept, scroll copy and
// bottom row fill, result strobe.
// ----------------------------------------------------------------------------
module tcw_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  tcw_pkg::sts_t sts,
  output tcw_pkg::cmd_t cmd,
  output logic          busy,
  output logic          done
);

  localparam logic [2:0] S_CLEAR   = 3'd0;
  localparam logic [2:0] S_IDLE    = 3'd1;
  localparam logic [2:0] S_COPY_RD = 3'd2;
  localparam logic [2:0] S_COPY_WR = 3'd3;
  localparam logic [2:0] S_BLANK   = 3'd4;
  localparam logic [2:0] S_RESP    = 3'd5;

  logic [2:0] state;
  logic [2:0] state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // Next state and commands
  always_comb begin
    state_next   = state;
    cmd          = '0;
    unique case (state)
      S_CLEAR: begin
        cmd.clear_wr = 1'b1;
        if (sts.fill_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (start) begin
          cmd.accept = 1'b1;
          state_next = sts.will_scroll ? S_COPY_RD : S_RESP;
        end
      end
      S_COPY_RD: begin
        cmd.copy_rd = 1'b1;
        state_next  = S_COPY_WR;
      end
      S_COPY_WR: begin
        cmd.copy_wr = 1'b1;
        state_next  = sts.copy_last ? S_BLANK : S_COPY_RD;
      end
      S_BLANK: begin
        cmd.blank_wr = 1'b1;
        if (sts.fill_last) state_next = S_RESP;
      end
      S_RESP: begin
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  assign busy = (state != S_IDLE);
  assign done = (state == S_RESP);

endmodule

// ===== rtl/core/tcw_datapath.sv =====
// ----------------------------------------------------------------------------
// tcw_datapath
// Screen store, cursor, color register, sweep counter and result fields.
// ----------------------------------------------------------------------------
module tcw_datapath #(
  parameter int COLUMNS = tcw_pkg::COLUMNS_DEFAULT,
  parameter int ROWS    = tcw_pkg::ROWS_DEFAULT
) (
  input  logic             clk,
  input  logic             rst,
  input  tcw_pkg::item_t   item,
  input  logic             cfg_we,
  input  logic [7:0]       cfg_data,
  input  tcw_pkg::cmd_t    cmd,
  output tcw_pkg::sts_t    sts,
  output tcw_pkg::result_t result
);

  localparam int CELLS = COLUMNS * ROWS;
  localparam int AW    = $clog2(CELLS);
  localparam int CW    = $clog2(COLUMNS);
  localparam int RW    = $clog2(ROWS);

  localparam logic [CW-1:0] COL_LAST       = CW'(COLUMNS - 1);
  localparam logic [RW-1:0] ROW_LAST       = RW'(ROWS - 1);
  localparam logic [AW-1:0] COLS_A         = AW'(COLUMNS);
  localparam logic [AW-1:0] CNT_COPY_LAST  = AW'(CELLS - COLUMNS - 1);
  localparam logic [AW-1:0] CNT_FILL_LAST  = AW'(CELLS - 1);

  logic [15:0]   mem [CELLS];
  logic [15:0]   rdata;
  logic [CW-1:0] col;
  logic [RW-1:0] row;
  logic [CW-1:0] col_next;
  logic [RW-1:0] row_next;
  logic          scroll;
  logic [7:0]    text_color;
  logic [AW-1:0] cnt;
  logic [AW-1:0] pos;
  logic          mode_q;
  logic          in_range_q;
  logic          scrolled_q;
  logic          in_range;
  logic          we;
  logic [AW-1:0] waddr;
  logic [15:0]   wdata;
  logic [AW-1:0] raddr;

  // Linear cursor position
  assign pos      = AW'(row) * COLS_A + AW'(col);
  assign in_range = (32'(item.cell_index) < CELLS);

  // Cursor advance for a put item
  always_comb begin
    col_next = col;
    row_next = row;
    scroll   = 1'b0;
    if (item.mode == tcw_pkg::MODE_PUT) begin
      if (item.char_code == tcw_pkg::NEWLINE_CODE || col == COL_LAST) begin
        col_next = '0;
        if (row == ROW_LAST) scroll = 1'b1;
        else row_next = row + 1'b1;
      end else begin
        col_next = col + 1'b1;
      end
    end
  end

  // Color register
  always_ff @(posedge clk) begin
    if (rst) begin
      text_color <= tcw_pkg::TEXT_COLOR_RESET;
    end else if (cfg_we) begin
      text_color <= cfg_data;
    end
  end

  // Cursor and sweep counter
  always_ff @(posedge clk) begin
    if (rst) begin
      col <= '0;
      row <= '0;
      cnt <= '0;
    end else begin
      if (cmd.accept) begin
        col <= col_next;
        row <= row_next;
        cnt <= '0;
      end
      if (cmd.clear_wr || cmd.copy_wr || cmd.blank_wr) begin
        cnt <= cnt + 1'b1;
      end
    end
  end

  // Per-item result flags
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      mode_q     <= item.mode;
      in_range_q <= in_range;
      scrolled_q <= scroll;
    end
  end

  // Store port select
  always_comb begin
    we    = 1'b0;
    waddr = cnt;
    wdata = tcw_pkg::RESET_CELL;
    raddr = AW'(item.cell_index);
    if (cmd.accept) begin
      we    = (item.mode == tcw_pkg::MODE_PUT) &&
              (item.char_code != tcw_pkg::NEWLINE_CODE);
      waddr = pos;
      wdata = {text_color, item.char_code};
    end else if (cmd.clear_wr) begin
      we    = 1'b1;
    end else if (cmd.copy_wr) begin
      we    = 1'b1;
      wdata = rdata;
    end else if (cmd.blank_wr) begin
      we    = 1'b1;
      wdata = {text_color, tcw_pkg::BLANK_CODE};
    end
    if (cmd.copy_rd) raddr = cnt + COLS_A;
  end

  // Screen store, registered read
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

  assign sts.will_scroll = scroll;
  assign sts.copy_last   = (cnt == CNT_COPY_LAST);
  assign sts.fill_last   = (cnt == CNT_FILL_LAST);

  assign result.cursor_offset = 11'(pos);
  assign result.cell_data     = (mode_q == tcw_pkg::MODE_READ && in_range_q) ? rdata : '0;
  assign result.scrolled      = scrolled_q;

endmodule

// ===== rtl/core/text_console_writer_core.sv =====
// ----------------------------------------------------------------------------
// text_console_writer_core
// Character terminal over a COLUMNS x ROWS cell store with cursor and scroll.
// ----------------------------------------------------------------------------
// A put or read transaction is accepted when start is high and busy low; unless
// it scrolls, its result appears with done for one cycle on the next cycle, and
// the receiver has no way to stall it. A put that scrolls first runs a rows-up
// copy of every cell below the top row (a read and a write per cell through the
// single store port pair), then one blank write per bottom-row cell, before done.
// After reset, busy stays high while the store is swept to blanks; cfg_we writes
// of the color register are taken at any time.
module text_console_writer_core #(
  parameter int COLUMNS = tcw_pkg::COLUMNS_DEFAULT,
  parameter int ROWS    = tcw_pkg::ROWS_DEFAULT
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  tcw_pkg::item_t   item,
  output logic             done,
  output tcw_pkg::result_t result,
  input  logic             cfg_we,
  input  logic [7:0]       cfg_data
);

  localparam int CELLS = COLUMNS * ROWS;

  tcw_pkg::cmd_t cmd;
  tcw_pkg::sts_t sts;

  // Controller
  tcw_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .sts   (sts),
    .cmd   (cmd),
    .busy  (busy),
    .done  (done)
  );

  // Datapath
  tcw_datapath #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_datapath (
    .clk      (clk),
    .rst      (rst),
    .item     (item),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .cmd      (cmd),
    .sts      (sts),
    .result   (result)
  );

`ifndef SYNTHESIS
  // Result strobe lasts one cycle
  a_done_pulse: assert property (@(posedge clk) disable iff (rst)
    done |=> !done) else $error("done held more than one cycle");

  // Accepted transaction keeps the block busy
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy) else $error("not busy after accept");

  // A scrolling put returns no cell data
  a_scroll_data: assert property (@(posedge clk) disable iff (rst)
    (done && result.scrolled) |-> (result.cell_data == '0))
    else $error("cell data on scrolling put");

  // Cursor stays on screen
  a_cursor_range: assert property (@(posedge clk) disable iff (rst)
    done |-> (32'(result.cursor_offset) < CELLS))
    else $error("cursor offset off screen");
`endif

endmodule

// ===== sim/text_console_writer_core_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_console_writer_core_tb
// Self-checking bench for the text console writer. A class keeps its own copy
// of the screen cells, the cursor and the text color, predicts one result per
// accepted put or read transaction and checks each done strobe against the
// oldest prediction. Stimulus is a short directed set followed by random line
// traffic (reads, short words, newlines, long lines that wrap and scroll)
// under several text colors and sender idle rates.
// ----------------------------------------------------------------------------
module text_console_writer_core_tb;

  localparam int COLS  = tcw_pkg::COLUMNS_DEFAULT;
  localparam int LINES = tcw_pkg::ROWS_DEFAULT;
  localparam int CELLS = COLS * LINES;

  // Screen predictor and store of pending results
  class console_model;
    logic [15:0]      cells [CELLS];
    int               col;
    int               row;
    logic [7:0]       color;
    tcw_pkg::result_t pending[$];
    int               n_fail;

    function new();
      foreach (cells[i]) cells[i] = tcw_pkg::RESET_CELL;
      col    = 0;
      row    = 0;
      color  = tcw_pkg::TEXT_COLOR_RESET;
      n_fail = 0;
    endfunction

    // Move every row up by one and blank the bottom row in the current color
    function void scroll_up();
      for (int i = 0; i < CELLS - COLS; i++) cells[i] = cells[i + COLS];
      for (int i = CELLS - COLS; i < CELLS; i++) cells[i] = {color, tcw_pkg::BLANK_CODE};
    endfunction

    // Go to column 0 of the next row; returns 1 when the screen scrolled
    function bit advance_row();
      col = 0;
      row++;
      if (row >= LINES) begin
        row = LINES - 1;
        scroll_up();
        return 1'b1;
      end
      return 1'b0;
    endfunction

    // Update the screen for one accepted transaction and queue its result
    function void apply_item(tcw_pkg::item_t it);
      tcw_pkg::result_t r;
      r = '0;
      if (it.mode == tcw_pkg::MODE_PUT) begin
        if (it.char_code == tcw_pkg::NEWLINE_CODE) begin
          r.scrolled = advance_row();
        end else begin
          cells[row * COLS + col] = {color, it.char_code};
          col++;
          if (col >= COLS) r.scrolled = advance_row();
        end
      end else if (it.cell_index < CELLS) begin
        r.cell_data = cells[it.cell_index];
      end
      r.cursor_offset = 11'(row * COLS + col);
      pending.push_back(r);
    endfunction

    // Compare one result transaction with the oldest prediction
    function void check_result(tcw_pkg::result_t got);
      tcw_pkg::result_t want;
      if (pending.size() == 0) begin
        $error("unexpected result: cursor_offset %0d cell_data %04h scrolled %0b",
               got.cursor_offset, got.cell_data, got.scrolled);
        n_fail++;
        return;
      end
      want = pending.pop_front();
      if (got.cursor_offset !== want.cursor_offset) begin
        $error("cursor_offset: expected %0d, actual %0d",
               want.cursor_offset, got.cursor_offset);
        n_fail++;
      end
      if (got.cell_data !== want.cell_data) begin
        $error("cell_data: expected %04h, actual %04h", want.cell_data, got.cell_data);
        n_fail++;
      end
      if (got.scrolled !== want.scrolled) begin
        $error("scrolled: expected %0b, actual %0b", want.scrolled, got.scrolled);
        n_fail++;
      end
    endfunction
  endclass

  logic             clk      = 1'b0;
  logic             rst      = 1'b1;
  logic             start    = 1'b0;
  logic             busy;
  tcw_pkg::item_t   item_in  = '0;
  logic             done;
  tcw_pkg::result_t result_out;
  logic             cfg_we   = 1'b0;
  logic [7:0]       cfg_data = '0;

  console_model model;
  int           idle_pct;

  text_console_writer_core #(
    .COLUMNS (COLS),
    .ROWS    (LINES)
  ) i_dut (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .busy     (busy),
    .item     (item_in),
    .done     (done),
    .result   (result_out),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Result monitor: done marks a result for exactly one cycle
  always @(posedge clk) begin
    if (!rst && done) model.check_result(result_out);
  end

  // Offer one transaction after random idle cycles, hold it until accepted
  task automatic send_item(input tcw_pkg::item_t it);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start   <= 1'b1;
    item_in <= it;
    do @(posedge clk); while (busy);
    model.apply_item(it);
  endtask

  task automatic put_char(input logic [7:0] code);
    tcw_pkg::item_t it;
    it.mode       = tcw_pkg::MODE_PUT;
    it.char_code  = code;
    it.cell_index = 11'($urandom);
    send_item(it);
  endtask

  task automatic read_cell(input logic [10:0] idx);
    tcw_pkg::item_t it;
    it.mode       = tcw_pkg::MODE_READ;
    it.char_code  = 8'($urandom);
    it.cell_index = idx;
    send_item(it);
  endtask

  // Hold off until every predicted result has arrived and the block is idle
  task automatic drain();
    if (start) start <= 1'b0;
    while (model.pending.size() != 0 || busy) @(posedge clk);
  endtask

  // Change the text color with the block idle
  task automatic write_color(input logic [7:0] value);
    drain();
    repeat (4) @(posedge clk);
    cfg_we   <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    model.color = value;
    cfg_we <= 1'b0;
  endtask

  // Random console traffic: reads, short words, newlines, long wrapping lines
  task automatic run_traffic(input int n_items);
    int         sent;
    int         pick;
    int         len;
    int         base;
    logic [7:0] code;
    sent = 0;
    while (sent < n_items) begin
      pick = $urandom_range(99);
      if (pick < 2) drain();
      if (pick < 25) begin
        read_cell(11'($urandom_range(CELLS - 1)));
        sent++;
      end else if (pick < 50) begin
        // reads around the cursor catch recent writes and the cleared row
        base = (model.row > 0 && $urandom_range(1)) ? model.row - 1 : model.row;
        read_cell(11'(base * COLS + $urandom_range(COLS - 1)));
        sent++;
      end else if (pick < 55) begin
        read_cell(11'($urandom_range(2047)));
        sent++;
      end else if (pick < 83) begin
        len = $urandom_range(1, 6);
        repeat (len) put_char(8'($urandom_range(255)));
        sent += len;
      end else if (pick < 97) begin
        put_char(tcw_pkg::NEWLINE_CODE);
        sent++;
      end else begin
        // long line without newlines so the column wraps
        len = $urandom_range(40, 100);
        repeat (len) begin
          code = 8'($urandom_range(255));
          if (code == tcw_pkg::NEWLINE_CODE) code = tcw_pkg::BLANK_CODE;
          put_char(code);
        end
        sent += len;
      end
    end
  endtask

  // Main sequence
  initial begin
    model    = new();
    idle_pct = 0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Directed: reset contents, range edges, ignored fields, newline handling
    idle_pct = 20;
    read_cell(11'd0);
    read_cell(11'(CELLS - 1));
    read_cell(11'(CELLS));
    read_cell(11'h7FF);
    read_cell(11'd1024);
    put_char(8'h41);
    put_char(8'h00);
    put_char(8'hFF);
    put_char(8'h09);
    read_cell(11'd0);
    read_cell(11'd2);
    read_cell(11'd3);
    put_char(tcw_pkg::NEWLINE_CODE);
    put_char(tcw_pkg::NEWLINE_CODE);
    put_char(tcw_pkg::BLANK_CODE);
    put_char(8'h7E);
    read_cell(11'(2 * COLS));
    read_cell(11'(2 * COLS + 1));
    read_cell(11'(COLS));
    put_char(tcw_pkg::NEWLINE_CODE);
    read_cell(11'(3 * COLS - 1));

    // Random phases under different colors and sender idle rates
    write_color(8'hFF);
    idle_pct = 30;
    run_traffic(283);

    write_color(8'h00);
    idle_pct = 63;
    run_traffic(283);

    write_color(8'($urandom_range(1, 254)));
    idle_pct = 0;
    run_traffic(284);

    drain();
    repeat (10) @(posedge clk);
    if (model.n_fail == 0 && model.pending.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // Run time guard
  initial begin
    #400_000_000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule
